>>> rtl/core/sbh_pkg.sv
// ----------------------------------------------------------------------------
// sbh_pkg
// Shared types and constants of the string bucket hash block.
// ----------------------------------------------------------------------------
package sbh_pkg;

  // field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned HASH_W   = 32;
  localparam int unsigned TS_W     = 21;
  localparam int unsigned BUCKET_W = 20;
  localparam int unsigned PEND_W   = 24;
  localparam int unsigned POS_W    = 2;

  // table size limits
  localparam logic [TS_W-1:0] MAX_TABLE_SIZE = TS_W'(1048576);
  localparam logic [TS_W-1:0] TS_RESET       = TS_W'(256);

  // one remainder bit per divider step
  localparam int unsigned DIV_STEPS = HASH_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  // controller states
  typedef enum logic [2:0] {
    S_RUN  = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } sbh_state_t;

  // controller to datapath
  typedef struct packed {
    logic take;      // accept the current input word
    logic start;     // last word accepted: close the name, load the divider
    logic div_step;  // run one divider step
    logic out_load;  // move the remainder into the output register
  } sbh_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_held;  // output register full and stalled
  } sbh_status_t;

endpackage

>>> rtl/core/sbh_ctrl.sv
// ----------------------------------------------------------------------------
// sbh_ctrl
// Controller: accepts words, sequences the serial divider, loads the result.
// ----------------------------------------------------------------------------
module sbh_ctrl import sbh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        last,
  output logic        in_stall,
  input  sbh_status_t status,
  output sbh_cmd_t    cmd
);

  sbh_state_t        state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic              accept;

  // input handshake
  assign accept   = in_valid && (state == S_RUN);
  assign in_stall = (state != S_RUN);

  // commands
  always_comb begin
    cmd.take     = accept;
    cmd.start    = accept && last;
    cmd.div_step = (state == S_DIV);
    cmd.out_load = (state == S_DONE) && !status.out_held;
  end

  // next state
  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      S_RUN: begin
        step_next = '0;
        if (accept && last) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        step_next = step + STEP_W'(1);
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!status.out_held) begin
          state_next = S_RUN;
        end
      end
      default: begin
        state_next = S_RUN;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

>>> rtl/core/sbh_datapath.sv
// ----------------------------------------------------------------------------
// sbh_datapath
// Word gathering, XOR accumulation, tail add, serial modulo, output register.
// ----------------------------------------------------------------------------
module sbh_datapath import sbh_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  sbh_cmd_t            cmd,
  output sbh_status_t         status,
  input  logic [BYTE_W-1:0]   name_byte,
  input  logic                last,
  input  logic                empty_req,
  input  logic                cfg_we,
  input  logic [TS_W-1:0]     cfg_wdata,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [BUCKET_W-1:0] bucket,
  output logic [HASH_W-1:0]   raw_hash
);

  logic [TS_W-1:0]     table_size;
  logic [HASH_W-1:0]   acc, acc_next;
  logic [PEND_W-1:0]   pend, pend_next;
  logic [POS_W-1:0]    pos, pos_next;
  logic [HASH_W-1:0]   word;
  logic [HASH_W-1:0]   final_sum;
  logic [HASH_W-1:0]   raw;
  logic [HASH_W-1:0]   dividend;
  logic [BUCKET_W-1:0] rem;
  logic [TS_W-1:0]     divisor;
  logic [TS_W-1:0]     eff_size;
  logic [TS_W-1:0]     trial;
  logic                fits;

  // table size register
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= TS_RESET;
    end else if (cfg_we) begin
      table_size <= cfg_wdata;
    end
  end

  // byte gathering into little-endian words
  always_comb begin
    word     = {8'd0, pend} | ({24'd0, name_byte} << {pos, 3'b000});
    acc_next = acc;
    pend_next = pend;
    pos_next = pos;
    if (!empty_req) begin
      if (pos == POS_W'(3)) begin
        acc_next  = acc ^ word;
        pend_next = '0;
        pos_next  = '0;
      end else begin
        pend_next = word[PEND_W-1:0];
        pos_next  = pos + POS_W'(1);
      end
    end
  end

  // leftover bytes added onto the accumulator
  always_comb begin
    final_sum = acc_next;
    if (pos_next > POS_W'(0)) final_sum = final_sum + {24'd0, pend_next[7:0]};
    if (pos_next > POS_W'(1)) final_sum = final_sum + {24'd0, pend_next[15:8]};
    if (pos_next > POS_W'(2)) final_sum = final_sum + {24'd0, pend_next[23:16]};
  end

  // clamp the modulus to 1 .. max
  always_comb begin
    eff_size = table_size;
    if (table_size == '0) eff_size = TS_W'(1);
    if (table_size > MAX_TABLE_SIZE) eff_size = MAX_TABLE_SIZE;
  end

  // name state, cleared at the end of each name
  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      pend <= '0;
      pos  <= '0;
    end else if (cmd.take) begin
      if (last) begin
        acc  <= '0;
        pend <= '0;
        pos  <= '0;
      end else begin
        acc  <= acc_next;
        pend <= pend_next;
        pos  <= pos_next;
      end
    end
  end

  // restoring divider step, remainder only
  assign trial = {rem, dividend[HASH_W-1]};
  assign fits  = (trial >= divisor);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      raw      <= final_sum;
      dividend <= final_sum;
      rem      <= '0;
      divisor  <= eff_size;
    end else if (cmd.div_step) begin
      dividend <= {dividend[HASH_W-2:0], 1'b0};
      if (fits) begin
        rem <= BUCKET_W'(trial - divisor);
      end else begin
        rem <= trial[BUCKET_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      bucket   <= rem;
      raw_hash <= raw;
    end
  end

  assign status.out_held = out_valid && out_stall;

endmodule

>>> rtl/core/string_bucket_hash.sv
// A word without last is taken as soon as it is offered; a word with last gives
// its result after the 32 remainder steps in S_DIV and the load from S_DONE.
// Throughput: one word per cycle within a name; the word that ends a name
// holds the input stalled while the one-bit-per-cycle divider runs, and
// longer while a finished result waits on a stalled output register.
// Reset (rst, synchronous): table_size returns to 256, accumulator and
// partial word clear, no result is pending.
// ----------------------------------------------------------------------------
// string_bucket_hash
// Hashes a byte-serial name and reduces it modulo the table size.
// ----------------------------------------------------------------------------
module string_bucket_hash import sbh_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [BYTE_W-1:0]   name_byte,
  input  logic                last,
  input  logic                empty_req,
  input  logic                cfg_we,
  input  logic [TS_W-1:0]     cfg_wdata,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [BUCKET_W-1:0] bucket,
  output logic [HASH_W-1:0]   raw_hash
);

  sbh_cmd_t    cmd;
  sbh_status_t status;

  // controller
  sbh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last     (last),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  sbh_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .name_byte (name_byte),
    .last      (last),
    .empty_req (empty_req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .bucket    (bucket),
    .raw_hash  (raw_hash)
  );

endmodule

>>> rtl/core/sbh_checker.sv
// ----------------------------------------------------------------------------
// sbh_checker
// Port-level checks of the string bucket hash block.
// ----------------------------------------------------------------------------
module sbh_checker import sbh_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                last,
  input logic                out_valid,
  input logic                out_stall,
  input logic [BUCKET_W-1:0] bucket,
  input logic [HASH_W-1:0]   raw_hash
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(bucket) && $stable(raw_hash))
    else $error("result word changed while stalled");

  // the end of a name starts the divider and stalls input
  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last |=> in_stall)
    else $error("input not stalled after end of name");

  // a word inside a name never stalls the next one
  a_mid_flows: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !last |=> !in_stall)
    else $error("input stalled inside a name");

  // a new result only appears at the end of a division
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a division");

endmodule

bind string_bucket_hash sbh_checker u_sbh_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .last      (last),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .bucket    (bucket),
  .raw_hash  (raw_hash)
);
